// ===== sv/rfsp_pkg.sv =====
// Package for the remote frame scheduler and packer.
// Holds the payload structs, the queue entry type, codes and constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package rfsp_pkg;

  // Frame bytes and lengths.
  localparam logic [7:0] HDR0      = 8'hA5;
  localparam logic [7:0] HDR1      = 8'h5A;
  localparam logic [7:0] ID_LOCAL  = 8'h01;
  localparam logic [7:0] ID_SECOND = 8'h02;
  localparam int unsigned SW_LOCAL_IDX = 3;
  localparam int unsigned FRAME_MAX    = 9;
  localparam int unsigned LEN_W        = 4;
  localparam logic [LEN_W-1:0] LEN_LOCAL  = LEN_W'(9);
  localparam logic [LEN_W-1:0] LEN_SECOND = LEN_W'(5);
  localparam logic [LEN_W-1:0] LEN_SINGLE = LEN_W'(1);

  // Configuration register reset values.
  localparam logic [15:0] RST_TRIGGER = 16'd600;
  localparam logic [15:0] RST_RELEASE = 16'd550;
  localparam logic [15:0] RST_PERIOD  = 16'd25;

  // Depth of the queue between the front and the back.
  localparam int unsigned DEF_FIFO_DEPTH = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_READY = 3'd0,
    CFG_TRIGGER    = 3'd1,
    CFG_RELEASE    = 3'd2,
    CFG_TX_PERIOD  = 3'd3
  } rfsp_cfg_e;

  typedef enum logic [2:0] {
    OUT_NOT_DUE   = 3'd0,
    OUT_NOT_READY = 3'd1,
    OUT_BUSY      = 3'd2,
    OUT_SENT      = 3'd3,
    OUT_REFUSED   = 3'd4
  } rfsp_outcome_e;

  typedef struct packed {
    logic [31:0] now_time;
    logic        aux_high;
    logic        uart_idle;
    logic        tx_accept;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [15:0] left_trigger;
    logic [15:0] right_trigger;
    logic [11:0] key_bits;
    logic [5:0]  switch_bits;
  } rfsp_in_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [2:0]  outcome;
    logic [31:0] frames_sent;
    logic [31:0] tx_errors;
    logic [31:0] busy_skips;
    logic [31:0] ready_skips;
  } rfsp_out_t;

  // One classified poll, as handed from the front to the back.
  typedef struct packed {
    logic [FRAME_MAX-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
    rfsp_outcome_e             outcome;
    logic [31:0]               frames_sent;
    logic [31:0]               tx_errors;
    logic [31:0]               busy_skips;
    logic [31:0]               ready_skips;
  } rfsp_desc_t;

endpackage

`default_nettype wire

// ===== sv/rfsp_front.sv =====
// Front part: configuration registers, due-time scheduling, skip checks,
// shoulder hysteresis, counters and frame building. Depends on rfsp_pkg.
`default_nettype none

module rfsp_front import rfsp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic                  full_i,
  input  wire rfsp_in_t              in_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       wr_en_o,
  output rfsp_desc_t                 desc_o
);

  logic        link_ready_q;
  logic [15:0] trigger_q, release_q, period_q;
  logic [31:0] due_q, due_d;
  logic        second_q, second_d;
  logic        lp_q, lp_d, rp_q, rp_d;
  logic [31:0] sent_q, sent_d, err_q, err_d, busy_q, busy_d, nrdy_q, nrdy_d;

  logic [31:0] period_ext, diff_now, diff_adv, due_adv, due_restart;
  logic        lp_new, rp_new;

  assign wr_en_o = push_i && !full_i;

  // Configuration writes; the channel is always ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_ready_q <= 1'b0;
      trigger_q    <= RST_TRIGGER;
      release_q    <= RST_RELEASE;
      period_q     <= RST_PERIOD;
    end else if (cfg_valid_i) begin
      case (rfsp_cfg_e'(cfg_index_i))
        CFG_LINK_READY: link_ready_q <= cfg_data_i[0];
        CFG_TRIGGER:    trigger_q    <= cfg_data_i;
        CFG_RELEASE:    release_q    <= cfg_data_i;
        CFG_TX_PERIOD:  period_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Due-time arithmetic, all four sums in parallel.
  assign period_ext  = {16'd0, period_q};
  assign diff_now    = in_i.now_time - due_q;
  assign diff_adv    = in_i.now_time - due_q - period_ext;
  assign due_adv     = due_q + period_ext;
  assign due_restart = in_i.now_time + period_ext;

  // Shoulder hysteresis candidates.
  assign lp_new = lp_q ? (in_i.left_trigger > release_q)
                       : (in_i.left_trigger >= trigger_q);
  assign rp_new = rp_q ? (in_i.right_trigger > release_q)
                       : (in_i.right_trigger >= trigger_q);

  // Classify the poll, update the state and build the queue entry.
  always_comb begin
    due_d    = due_q;
    second_d = second_q;
    lp_d     = lp_q;
    rp_d     = rp_q;
    sent_d   = sent_q;
    err_d    = err_q;
    busy_d   = busy_q;
    nrdy_d   = nrdy_q;

    desc_o         = '0;
    desc_o.len     = LEN_SINGLE;
    desc_o.outcome = OUT_NOT_DUE;

    if (!diff_now[31]) begin
      due_d = diff_adv[31] ? due_adv : due_restart;
      if (!link_ready_q) begin
        nrdy_d         = nrdy_q + 32'd1;
        desc_o.outcome = OUT_NOT_READY;
      end else if (!in_i.aux_high || !in_i.uart_idle) begin
        busy_d         = busy_q + 32'd1;
        desc_o.outcome = OUT_BUSY;
      end else begin
        if (!second_q) begin
          lp_d = lp_new;
          rp_d = rp_new;
        end
        if (!in_i.tx_accept) begin
          err_d          = err_q + 32'd1;
          desc_o.outcome = OUT_REFUSED;
        end else begin
          second_d        = !second_q;
          sent_d          = sent_q + 32'd1;
          desc_o.outcome  = OUT_SENT;
          desc_o.bytes[0] = HDR0;
          desc_o.bytes[1] = HDR1;
          if (!second_q) begin
            desc_o.len      = LEN_LOCAL;
            desc_o.bytes[2] = ID_LOCAL;
            desc_o.bytes[3] = in_i.left_x;
            desc_o.bytes[4] = in_i.left_y;
            desc_o.bytes[5] = in_i.right_x;
            desc_o.bytes[6] = in_i.right_y;
            desc_o.bytes[7] = {rp_new, lp_new, in_i.key_bits[5:0]};
            desc_o.bytes[8] = {7'd0, in_i.switch_bits[SW_LOCAL_IDX]};
          end else begin
            desc_o.len      = LEN_SECOND;
            desc_o.bytes[2] = ID_SECOND;
            desc_o.bytes[3] = {2'd0, in_i.key_bits[11:6]};
            desc_o.bytes[4] = {2'd0, in_i.switch_bits & ~(6'd1 << SW_LOCAL_IDX)};
          end
        end
      end
    end

    desc_o.frames_sent = sent_d;
    desc_o.tx_errors   = err_d;
    desc_o.busy_skips  = busy_d;
    desc_o.ready_skips = nrdy_d;
  end

  // State registers advance only on an accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q    <= '0;
      second_q <= 1'b0;
      lp_q     <= 1'b0;
      rp_q     <= 1'b0;
      sent_q   <= '0;
      err_q    <= '0;
      busy_q   <= '0;
      nrdy_q   <= '0;
    end else if (wr_en_o) begin
      due_q    <= due_d;
      second_q <= second_d;
      lp_q     <= lp_d;
      rp_q     <= rp_d;
      sent_q   <= sent_d;
      err_q    <= err_d;
      busy_q   <= busy_d;
      nrdy_q   <= nrdy_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rfsp_fifo.sv =====
// Short queue of classified polls between the front and the back.
// Register-based, one write and one read per cycle. Depends on rfsp_pkg.
`default_nettype none

module rfsp_fifo import rfsp_pkg::*; #(
  parameter int unsigned DEPTH = DEF_FIFO_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_en_i,
  input  wire rfsp_desc_t wr_data_i,
  input  wire logic       rd_en_i,
  output rfsp_desc_t      rd_data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rfsp_desc_t       store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o    = (count_q == CNT_FULL);
  assign empty_o   = (count_q == '0);
  assign rd_data_o = store_q[rd_ptr_q];

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (rd_en_i && !wr_en_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rfsp_back.sv =====
// Back part: walks the head queue entry one byte per result request.
// Frees the entry after its last byte is taken. Depends on rfsp_pkg.
`default_nettype none

module rfsp_back import rfsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire rfsp_desc_t head_i,
  input  wire logic       head_empty_i,
  input  wire logic       pop_i,
  output logic            head_pop_o,
  output rfsp_out_t       out_o
);

  logic [LEN_W-1:0] idx_q, idx_d;
  logic             take, is_last, is_sent;

  assign take    = pop_i && !head_empty_i;
  assign is_last = (idx_q == (head_i.len - LEN_W'(1)));
  assign is_sent = (head_i.outcome == OUT_SENT);

  assign head_pop_o = take && is_last;

  // Result fields from the head entry and the byte index.
  always_comb begin
    out_o.byte_valid  = is_sent;
    out_o.frame_byte  = is_sent ? head_i.bytes[idx_q] : 8'd0;
    out_o.last_byte   = is_last;
    out_o.outcome     = head_i.outcome;
    out_o.frames_sent = head_i.frames_sent;
    out_o.tx_errors   = head_i.tx_errors;
    out_o.busy_skips  = head_i.busy_skips;
    out_o.ready_skips = head_i.ready_skips;
  end

  // Byte index steps on each taken result and restarts at a frame's end.
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = is_last ? '0 : idx_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/remote_frame_scheduler_packer_unit.sv =====
// Top level of the remote frame scheduler and packer.
// Joins rfsp_front, rfsp_fifo and rfsp_back; depends on rfsp_pkg.
//
//  Channel   Ports                                   Direction  Accept when
//  poll      push_i, full_o, in_i                    in         push_i && !full_o
//  result    empty_o, pop_i, out_o                   out        pop_i && !empty_o
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,  in         cfg_valid_i && cfg_ready_o
//            cfg_data_i
//
// A poll is classified in the cycle it is accepted and its entry is in the
// queue on the next cycle; a poll may be accepted every cycle until the
// queue of FIFO_DEPTH entries fills. The back side gives one result per
// cycle while the queue is not empty and pop_i is high: nine for a sent local frame, five
// for a secondary frame, one otherwise, so the byte walk of the back part sets the
// sustained rate. Reset is asynchronous and clears all state but the queue storage;
// no clearing pass is needed. Either side may stall freely; the queue decouples them.
`default_nettype none

module remote_frame_scheduler_packer_unit import rfsp_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire rfsp_in_t              in_i,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output rfsp_out_t                  out_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic       wr_en, rd_en;
  rfsp_desc_t wr_desc, head_desc;

  assign cfg_ready_o = 1'b1;

  // Front: classify and pack each accepted poll.
  rfsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_i      (full_o),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .wr_en_o     (wr_en),
    .desc_o      (wr_desc)
  );

  // Queue between the two sides.
  rfsp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_desc),
    .rd_en_i   (rd_en),
    .rd_data_o (head_desc),
    .full_o    (full_o),
    .empty_o   (empty_o)
  );

  // Back: serialize the head entry into result requests.
  rfsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_desc),
    .head_empty_i (empty_o),
    .pop_i        (pop_i),
    .head_pop_o   (rd_en),
    .out_o        (out_o)
  );

  // A result without a frame byte always closes its poll.
  a_nobyte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !out_o.byte_valid) |-> out_o.last_byte)
    else $error("result without a frame byte is not marked last");

  // A full queue must have something to show.
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !empty_o)
    else $error("queue full while result side is empty");

  // Taking a byte that is not last leaves the rest of the frame waiting.
  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && !out_o.last_byte) |=> (!empty_o && out_o.byte_valid))
    else $error("frame interrupted before its last byte");

endmodule

`default_nettype wire
